/* rtl/core/sfd_pkg.sv */
// Shared constants and types of the sync frame deframer.
`timescale 1ns / 1ps

package sfd_pkg;

    localparam int unsigned PAYLOAD_DEPTH = 64;
    localparam int unsigned IDX_W = $clog2(PAYLOAD_DEPTH);
    localparam int unsigned LEN_W = $clog2(PAYLOAD_DEPTH + 1);

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYNC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SYNC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    localparam logic [6:0] MAX_PAYLOAD_RESET = 7'd64;
    localparam logic [7:0] FIRST_SYNC_RESET  = 8'd170;
    localparam logic [7:0] SECOND_SYNC_RESET = 8'd85;

    // output word layout: command, module, length, byte, index, padded to 40 bits
    localparam int unsigned OUT_DATA_W = 40;

    typedef struct packed {
        logic             start;
        logic [7:0]       command;
        logic [7:0]       module_id;
        logic [LEN_W-1:0] length;
    } t_frame_info;

    typedef struct packed {
        logic busy;
        logic out_free;
    } t_emit_status;

endpackage

/* rtl/core/sync_frame_deframer_xor_check_top.sv */
// Sync frame deframer with XOR check: stream in bytes, stream out payload words.
//
// Slave stream takes one received byte per word. Frames are first sync, second
// sync, command, module, 16-bit little-endian length, payload and an XOR check
// over command through payload. Bad second sync, over-long length or a check
// mismatch return the parser to hunting for the first sync byte without output.
// Master stream gives one word per payload byte (tlast on the final one), or a
// single header-only word with tuser low for a frame of length zero.
// Bytes are taken at one per cycle. After the check byte of a good frame the
// payload store is read back at one word per cycle, the first word passing the
// read flag, the store's read register and the output register. A header-only word
// comes in the cycle after the check byte; input is held off while the readback runs.
// A stalled master side stops the readback; the input accepts again once the
// last read is in the output register. Reset (synchronous, active low) restores
// the register defaults and hunting; the payload store needs no clearing.
// Configuration writes are taken on any cycle with i_cfg_we high.
`timescale 1ns / 1ps

module sync_frame_deframer_xor_check_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] frame_command, [15:8] frame_module, [22:16] payload_length,
    // [30:23] payload_byte, [36:31] payload_index, [39:37] zero
    output logic [sfd_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,   // [0] has_payload
    output logic                           m_axis_tlast    // last_of_frame
);
    import sfd_pkg::*;

    t_frame_info      frame;
    t_emit_status     status;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [7:0]       mem_rdata;

    logic [7:0]       out_cmd;
    logic [7:0]       out_mod;
    logic [LEN_W-1:0] out_len;
    logic [7:0]       out_byte;
    logic [IDX_W-1:0] out_idx;

    sfd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .i_byte     (s_axis_tdata),
        .o_ready    (s_axis_tready),
        .i_status   (status),
        .o_mem_we   (mem_we),
        .o_mem_addr (mem_waddr),
        .o_mem_data (mem_wdata),
        .o_frame    (frame)
    );

    sfd_ram #(
        .WIDTH (8),
        .DEPTH (PAYLOAD_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sfd_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_frame       (frame),
        .o_status      (status),
        .o_mem_re      (mem_re),
        .o_mem_addr    (mem_raddr),
        .i_mem_data    (mem_rdata),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_command     (out_cmd),
        .o_module      (out_mod),
        .o_length      (out_len),
        .o_has_payload (m_axis_tuser),
        .o_byte        (out_byte),
        .o_index       (out_idx),
        .o_last        (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_idx, out_byte, out_len, out_mod, out_cmd};

endmodule

/* rtl/core/sfd_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sfd_parser.sv */
// Frame parser: configuration registers, header and checksum tracking, payload write.
`timescale 1ns / 1ps

module sfd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [sfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                          i_valid,
    input  logic [7:0]                    i_byte,
    output logic                          o_ready,
    input  sfd_pkg::t_emit_status         i_status,
    output logic                          o_mem_we,
    output logic [sfd_pkg::IDX_W-1:0]     o_mem_addr,
    output logic [7:0]                    o_mem_data,
    output sfd_pkg::t_frame_info          o_frame
);
    import sfd_pkg::*;

    localparam logic [2:0] PH_SYNC1 = 3'd0;
    localparam logic [2:0] PH_SYNC2 = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd2;
    localparam logic [2:0] PH_MOD   = 3'd3;
    localparam logic [2:0] PH_LENLO = 3'd4;
    localparam logic [2:0] PH_LENHI = 3'd5;
    localparam logic [2:0] PH_DATA  = 3'd6;
    localparam logic [2:0] PH_CHECK = 3'd7;

    logic [7:0]       r_first_sync;
    logic [7:0]       r_second_sync;
    logic [6:0]       r_max_payload;

    logic [2:0]       r_phase, n_phase;
    logic [7:0]       r_check, n_check;
    logic [7:0]       r_cmd, n_cmd;
    logic [7:0]       r_mod, n_mod;
    logic [7:0]       r_len_lo, n_len_lo;
    logic [LEN_W-1:0] r_cnt, n_cnt;

    logic             accept;
    logic [LEN_W-1:0] cnt_inc;
    logic [7:0]       limit;
    logic             start;

    assign o_ready = !i_status.busy && ((r_phase != PH_CHECK) || i_status.out_free);
    assign accept  = i_valid && o_ready;
    assign cnt_inc = r_cnt + LEN_W'(1);

    // limit is the smaller of the register and the store depth
    always_comb begin
        if (r_max_payload > 7'(PAYLOAD_DEPTH)) begin
            limit = 8'(PAYLOAD_DEPTH);
        end else begin
            limit = {1'b0, r_max_payload};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= FIRST_SYNC_RESET;
            r_second_sync <= SECOND_SYNC_RESET;
            r_max_payload <= MAX_PAYLOAD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_SYNC:  r_first_sync  <= i_cfg_data;
                CFG_SECOND_SYNC: r_second_sync <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_check  = r_check;
        n_cmd    = r_cmd;
        n_mod    = r_mod;
        n_len_lo = r_len_lo;
        n_cnt    = r_cnt;
        start    = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_SYNC1: begin
                    if (i_byte == r_first_sync) begin
                        n_phase = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    // wrong second sync drops back without re-examining the byte
                    n_phase = (i_byte == r_second_sync) ? PH_CMD : PH_SYNC1;
                    n_check = '0;
                    n_cnt   = '0;
                end
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_check = r_check ^ i_byte;
                    n_phase = PH_MOD;
                end
                PH_MOD: begin
                    n_mod   = i_byte;
                    n_check = r_check ^ i_byte;
                    n_phase = PH_LENLO;
                end
                PH_LENLO: begin
                    n_len_lo = i_byte;
                    n_check  = r_check ^ i_byte;
                    n_phase  = PH_LENHI;
                end
                PH_LENHI: begin
                    n_cnt = '0;
                    if ((i_byte != 8'd0) || (r_len_lo > limit)) begin
                        n_phase = PH_SYNC1;
                        n_check = '0;
                    end else begin
                        n_check = r_check ^ i_byte;
                        n_phase = (r_len_lo == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_cnt   = cnt_inc;
                    n_check = r_check ^ i_byte;
                    if ({1'b0, cnt_inc} >= r_len_lo) begin
                        n_phase = PH_CHECK;
                    end
                end
                PH_CHECK: begin
                    start   = (i_byte == r_check);
                    n_phase = PH_SYNC1;
                    n_check = '0;
                    n_cnt   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SYNC1;
            r_check  <= '0;
            r_cmd    <= '0;
            r_mod    <= '0;
            r_len_lo <= '0;
            r_cnt    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_check  <= n_check;
            r_cmd    <= n_cmd;
            r_mod    <= n_mod;
            r_len_lo <= n_len_lo;
            r_cnt    <= n_cnt;
        end
    end

    assign o_mem_we   = accept && (r_phase == PH_DATA);
    assign o_mem_addr = r_cnt[IDX_W-1:0];
    assign o_mem_data = i_byte;

    assign o_frame.start     = start;
    assign o_frame.command   = r_cmd;
    assign o_frame.module_id = r_mod;
    assign o_frame.length    = r_len_lo[LEN_W-1:0];

endmodule

/* rtl/core/sfd_emitter.sv */
// Result emitter: reads the payload store back and drives the output register.
`timescale 1ns / 1ps

module sfd_emitter (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sfd_pkg::t_frame_info      i_frame,
    output sfd_pkg::t_emit_status     o_status,
    output logic                      o_mem_re,
    output logic [sfd_pkg::IDX_W-1:0] o_mem_addr,
    input  logic [7:0]                i_mem_data,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_command,
    output logic [7:0]                o_module,
    output logic [sfd_pkg::LEN_W-1:0] o_length,
    output logic                      o_has_payload,
    output logic [7:0]                o_byte,
    output logic [sfd_pkg::IDX_W-1:0] o_index,
    output logic                      o_last
);
    import sfd_pkg::*;

    logic             r_reading;
    logic [LEN_W-1:0] r_rd_idx;
    logic             r_rd_vld;
    logic [IDX_W-1:0] r_pend_idx;
    logic             r_pend_last;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_cmd;
    logic [7:0]       r_mod;

    logic             r_out_vld;
    logic [7:0]       r_out_cmd;
    logic [7:0]       r_out_mod;
    logic [LEN_W-1:0] r_out_len;
    logic             r_out_has;
    logic [7:0]       r_out_byte;
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_last;

    logic             out_free;
    logic             load;
    logic             rd_en;
    logic [LEN_W-1:0] rd_next;
    logic             hdr_only;

    assign out_free = !r_out_vld || i_ready;
    assign load     = r_rd_vld && out_free;
    assign rd_en    = r_reading && (!r_rd_vld || load);
    assign rd_next  = r_rd_idx + LEN_W'(1);
    assign hdr_only = i_frame.start && (i_frame.length == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reading <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_idx  <= '0;
        end else begin
            if (i_frame.start && !hdr_only) begin
                r_reading <= 1'b1;
                r_rd_idx  <= '0;
            end else if (rd_en) begin
                r_rd_idx <= rd_next;
                if (rd_next == r_len) begin
                    r_reading <= 1'b0;
                end
            end
            if (rd_en) begin
                r_rd_vld <= 1'b1;
            end else if (load) begin
                r_rd_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.start) begin
            r_len <= i_frame.length;
            r_cmd <= i_frame.command;
            r_mod <= i_frame.module_id;
        end
        if (rd_en) begin
            r_pend_idx  <= r_rd_idx[IDX_W-1:0];
            r_pend_last <= (rd_next == r_len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (hdr_only || load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_only) begin
            r_out_cmd  <= i_frame.command;
            r_out_mod  <= i_frame.module_id;
            r_out_len  <= '0;
            r_out_has  <= 1'b0;
            r_out_byte <= '0;
            r_out_idx  <= '0;
            r_out_last <= 1'b1;
        end else if (load) begin
            r_out_cmd  <= r_cmd;
            r_out_mod  <= r_mod;
            r_out_len  <= r_len;
            r_out_has  <= 1'b1;
            r_out_byte <= i_mem_data;
            r_out_idx  <= r_pend_idx;
            r_out_last <= r_pend_last;
        end
    end

    assign o_mem_re   = rd_en;
    assign o_mem_addr = r_rd_idx[IDX_W-1:0];

    assign o_status.busy     = r_reading || r_rd_vld;
    assign o_status.out_free = out_free;

    assign o_valid       = r_out_vld;
    assign o_command     = r_out_cmd;
    assign o_module      = r_out_mod;
    assign o_length      = r_out_len;
    assign o_has_payload = r_out_has;
    assign o_byte        = r_out_byte;
    assign o_index       = r_out_idx;
    assign o_last        = r_out_last;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the sync frame deframer with XOR check.
`timescale 1ns / 1ps

module testbench;

    import sfd_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_BYTES  = 24;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int DIR_ROWS     = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // how a directed row is checked
    localparam logic [1:0] ROW_PREDICT = 2'd0;
    localparam logic [1:0] ROW_NONE    = 2'd1;
    localparam logic [1:0] ROW_HDR     = 2'd2;

    // shape of a generated frame
    localparam int FRAME_GOOD     = 0;
    localparam int FRAME_SPOILT   = 1;
    localparam int FRAME_OVERLONG = 2;

    typedef enum logic [2:0] {
        PH_SYNC1, PH_SYNC2, PH_CMD, PH_MOD, PH_LEN_LO, PH_LEN_HI, PH_DATA, PH_CHECK
    } t_rx_phase;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] module_id;
        logic [6:0] length;
        logic       has_payload;
        logic [7:0] data;
        logic [5:0] index;
        logic       last;
    } t_frame_word;

    typedef struct packed {
        logic [7:0] rx;
        logic [1:0] kind;
        logic [7:0] command;
        logic [7:0] module_id;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;

    sync_frame_deframer_xor_check_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // settings and parser state of the deframer as the bench sees them
    logic [7:0]  cfg_first_sync  = FIRST_SYNC_RESET;
    logic [7:0]  cfg_second_sync = SECOND_SYNC_RESET;
    logic [6:0]  cfg_max_payload = MAX_PAYLOAD_RESET;
    t_rx_phase   rx_phase = PH_SYNC1;
    logic [7:0]  run_xor = '0;
    logic [7:0]  held_cmd = '0;
    logic [7:0]  held_mod = '0;
    logic [15:0] len_word = '0;
    logic [6:0]  data_count = '0;
    logic [7:0]  payload_copy [PAYLOAD_DEPTH];

    t_frame_word frame_out [$];
    t_frame_word due_words [$];

    int errors = 0;
    int bytes_sent = 0;
    int payload_seen = 0;
    int header_seen = 0;
    int phases_run = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;

    t_dir_row dir_rows [DIR_ROWS];

    function automatic void restart_hunt();
        rx_phase   = PH_SYNC1;
        data_count = '0;
        run_xor    = '0;
    endfunction

    // advance the parser by one byte; completed frames land in frame_out
    function automatic void deframe_byte(input logic [7:0] rx);
        logic [6:0]  lim;
        t_frame_word w;
        lim = (cfg_max_payload > 7'(PAYLOAD_DEPTH)) ? 7'(PAYLOAD_DEPTH) : cfg_max_payload;
        frame_out = {};
        case (rx_phase)
            PH_SYNC1: begin
                if (rx == cfg_first_sync) rx_phase = PH_SYNC2;
            end
            PH_SYNC2: begin
                if (rx == cfg_second_sync) begin
                    rx_phase = PH_CMD;
                    run_xor  = '0;
                end else begin
                    restart_hunt();
                end
            end
            PH_CMD: begin
                held_cmd = rx;
                run_xor ^= rx;
                rx_phase = PH_MOD;
            end
            PH_MOD: begin
                held_mod = rx;
                run_xor ^= rx;
                rx_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_word = {8'h00, rx};
                run_xor ^= rx;
                rx_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_word[15:8] = rx;
                run_xor ^= rx;
                if (len_word > {9'd0, lim}) begin
                    restart_hunt();
                end else if (len_word == 16'd0) begin
                    rx_phase = PH_CHECK;
                end else begin
                    data_count = '0;
                    rx_phase   = PH_DATA;
                end
            end
            PH_DATA: begin
                if (data_count < 7'(PAYLOAD_DEPTH)) payload_copy[data_count[5:0]] = rx;
                data_count = data_count + 7'd1;
                run_xor ^= rx;
                if ({9'd0, data_count} >= len_word) rx_phase = PH_CHECK;
            end
            default: begin
                if (rx == run_xor) begin
                    if (len_word == 16'd0) begin
                        w = '0;
                        w.command   = held_cmd;
                        w.module_id = held_mod;
                        w.last      = 1'b1;
                        frame_out.push_back(w);
                    end else begin
                        for (int k = 0; k < int'(len_word); k++) begin
                            w.command     = held_cmd;
                            w.module_id   = held_mod;
                            w.length      = len_word[6:0];
                            w.has_payload = 1'b1;
                            w.data        = payload_copy[k];
                            w.index       = 6'(k);
                            w.last        = (k + 1 == int'(len_word));
                            frame_out.push_back(w);
                        end
                    end
                end
                restart_hunt();
            end
        endcase
    endfunction

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic check_word();
        t_frame_word want;
        if (m_axis_tuser) payload_seen++;
        else header_seen++;
        if (due_words.size() == 0) begin
            $display("%0t: word with nothing expected, expected none, actual %h/%b/%b",
                     $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
            errors++;
        end else begin
            want = due_words.pop_front();
            compare_field("command", want.command, m_axis_tdata[7:0]);
            compare_field("module", want.module_id, m_axis_tdata[15:8]);
            compare_field("length", want.length, m_axis_tdata[22:16]);
            compare_field("payload byte", want.data, m_axis_tdata[30:23]);
            compare_field("index", want.index, m_axis_tdata[36:31]);
            compare_field("pad", 0, m_axis_tdata[39:37]);
            compare_field("has_payload", want.has_payload, m_axis_tuser);
            compare_field("last", want.last, m_axis_tlast);
        end
    endtask

    // receiver: check the old sample, then choose the next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_word();
        if (hold_asks != hold_seen) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d words outstanding", $time, due_words.size());
            $display("sync_frame_deframer_xor_check_top verification failed");
            $finish;
        end
    end

    // offer one byte, idling at random first; return at the accepting edge
    task automatic push_byte(input logic [7:0] rx);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= rx;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic feed(input logic [7:0] rx);
        push_byte(rx);
        deframe_byte(rx);
        foreach (frame_out[k]) due_words.push_back(frame_out[k]);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic settle_and_set(input logic [7:0] fs, input logic [7:0] ss,
                                  input logic [6:0] mp, input bit poke_spare);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_SYNC;
        i_cfg_data <= fs;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_SECOND_SYNC;
        i_cfg_data <= ss;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_MAX_PAYLOAD;
        i_cfg_data <= {1'b0, mp};
        @(posedge i_clk);
        // the spare index must leave every setting alone
        if (poke_spare) begin
            i_cfg_idx  <= CFG_SPARE;
            i_cfg_data <= 8'(~fs);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_first_sync  = fs;
        cfg_second_sync = ss;
        cfg_max_payload = mp;
        phases_run++;
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] mod,
                              input logic [15:0] len, input int shape);
        logic [7:0] body [$];
        logic [7:0] sum;
        body = {cmd, mod, len[7:0], len[15:8]};
        if (shape != FRAME_OVERLONG)
            for (int k = 0; k < int'(len); k++) body.push_back(8'($urandom));
        sum = '0;
        foreach (body[k]) sum ^= body[k];
        if (shape == FRAME_SPOILT) sum ^= 8'($urandom_range(255, 1));
        if (shape != FRAME_OVERLONG) body.push_back(sum);
        feed(cfg_first_sync);
        feed(cfg_second_sync);
        foreach (body[k]) feed(body[k]);
    endtask

    function automatic int pick_len(input int lim);
        int r;
        r = $urandom_range(99);
        if (r < 5) return lim;
        if (r < 80) return $urandom_range((lim < 6) ? lim : 6, 0);
        return $urandom_range(lim, 0);
    endfunction

    task automatic random_unit();
        int         lim;
        int         r;
        logic [7:0] x;
        lim = (int'(cfg_max_payload) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(cfg_max_payload);
        r = $urandom_range(99);
        if (r < 70) begin
            send_frame(8'($urandom), 8'($urandom), 16'(pick_len(lim)), FRAME_GOOD);
        end else if (r < 78) begin
            send_frame(8'($urandom), 8'($urandom), 16'(pick_len(lim)), FRAME_SPOILT);
        end else if (r < 84) begin
            send_frame(8'($urandom), 8'($urandom), 16'($urandom_range(65535, lim + 1)),
                       FRAME_OVERLONG);
        end else if (r < 90) begin
            // second sync wrong, possibly equal to the first sync value
            x = ($urandom_range(1)) ? cfg_first_sync : 8'($urandom);
            if (x == cfg_second_sync) x = ~x;
            feed(cfg_first_sync);
            feed(x);
        end else begin
            repeat ($urandom_range(6, 1)) feed(8'($urandom));
        end
    endtask

    task automatic random_phase();
        int target;
        target = bytes_sent + PHASE_BYTES;
        while (bytes_sent < target) random_unit();
    endtask

    initial begin
        dir_rows = '{
            // good header-only frame with reset settings
            {8'hAA, ROW_PREDICT, 8'h00, 8'h00}, {8'h55, ROW_PREDICT, 8'h00, 8'h00},
            {8'hFF, ROW_PREDICT, 8'h00, 8'h00}, {8'h00, ROW_PREDICT, 8'h00, 8'h00},
            {8'h00, ROW_PREDICT, 8'h00, 8'h00}, {8'h00, ROW_PREDICT, 8'h00, 8'h00},
            {8'hFF, ROW_HDR,     8'hFF, 8'h00},
            // bad second sync that is itself a first sync, not re-examined
            {8'hAA, ROW_PREDICT, 8'h00, 8'h00}, {8'hAA, ROW_PREDICT, 8'h00, 8'h00},
            {8'h55, ROW_NONE,    8'h00, 8'h00},
            // length of 256, over the limit
            {8'hAA, ROW_PREDICT, 8'h00, 8'h00}, {8'h55, ROW_PREDICT, 8'h00, 8'h00},
            {8'h01, ROW_PREDICT, 8'h00, 8'h00}, {8'h02, ROW_PREDICT, 8'h00, 8'h00},
            {8'h00, ROW_PREDICT, 8'h00, 8'h00}, {8'h01, ROW_NONE,    8'h00, 8'h00},
            // one payload byte, check should be 80
            {8'hAA, ROW_PREDICT, 8'h00, 8'h00}, {8'h55, ROW_PREDICT, 8'h00, 8'h00},
            {8'hC3, ROW_PREDICT, 8'h00, 8'h00}, {8'h3C, ROW_PREDICT, 8'h00, 8'h00},
            {8'h01, ROW_PREDICT, 8'h00, 8'h00}, {8'h00, ROW_PREDICT, 8'h00, 8'h00},
            {8'h7E, ROW_PREDICT, 8'h00, 8'h00}, {8'h7F, ROW_NONE,    8'h00, 8'h00}
        };
        foreach (payload_copy[k]) payload_copy[k] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 8;
        dst_idle_pct = 71;
        for (int i = 0; i < DIR_ROWS; i++) begin : directed
            t_frame_word w;
            push_byte(dir_rows[i].rx);
            deframe_byte(dir_rows[i].rx);
            if (dir_rows[i].kind == ROW_PREDICT) begin
                foreach (frame_out[k]) due_words.push_back(frame_out[k]);
            end else if (dir_rows[i].kind == ROW_HDR) begin
                w = '0;
                w.command   = dir_rows[i].command;
                w.module_id = dir_rows[i].module_id;
                w.last      = 1'b1;
                due_words.push_back(w);
            end
        end

        settle_and_set(8'hAA, 8'h55, 7'd64, 1'b0);
        // stall the receiver under a full-size frame so the input backs up
        hold_asks++;
        send_frame(8'h00, 8'hFF, 16'd64, FRAME_GOOD);
        send_frame(8'($urandom), 8'($urandom), 16'd3, FRAME_GOOD);
        send_frame(8'($urandom), 8'($urandom), 16'd0, FRAME_GOOD);
        random_phase();

        settle_and_set(8'h00, 8'hFF, 7'd0, 1'b1);
        random_phase();

        src_idle_pct = 71;
        dst_idle_pct = 8;
        settle_and_set(8'hFF, 8'h00, 7'd1, 1'b0);
        random_phase();
        wait_drained();
        random_phase();

        settle_and_set(8'h5A, 8'h5A, 7'd12, 1'b0);
        random_phase();

        src_idle_pct = 0;
        dst_idle_pct = 0;
        settle_and_set(8'($urandom), 8'($urandom), 7'($urandom_range(64, 0)), 1'b0);
        random_phase();

        settle_and_set(8'hAA, 8'h55, 7'd63, 1'b0);
        random_phase();

        wait_drained();
        $display("Fed %0d bytes over %0d setting phases besides reset defaults.",
                 bytes_sent, phases_run);
        $display("Checked %0d payload words and %0d header-only words.",
                 payload_seen, header_seen);
        if (errors == 0) begin
            $display("sync_frame_deframer_xor_check_top verification clean");
        end else begin
            $display("sync_frame_deframer_xor_check_top verification failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/sfd_pkg.sv
rtl/core/sfd_ram.sv
rtl/core/sfd_parser.sv
rtl/core/sfd_emitter.sv
rtl/core/sync_frame_deframer_xor_check_top.sv
dv/testbench.sv
